/* rtl/mfd_pkg.sv */
// Shared constants, types and sine table arithmetic for the modulated fractional delay unit.
package mfd_pkg;

  localparam int BUFFER_DEPTH_DEF    = 16384;
  localparam int CHANNELS_DEF        = 2;
  localparam int SINE_TABLE_SIZE_DEF = 1024;

  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 22;
  localparam int DEPTH_W  = 16;
  localparam int PHASE_W  = 32;
  localparam int SINE_W   = 16;
  localparam int FRAC_W   = 8;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_DELAY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEPTH = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STEP  = 2'd2;

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef struct packed {
    logic load;
    logic mul;
    logic tot;
    logic rd;
    logic mac;
    logic fin;
  } mfd_cmd_t;

  typedef struct packed {
    logic bypass;
  } mfd_sts_t;

  function automatic longint mul_q30(input longint x, input longint y);
    mul_q30 = (x * y) >>> 30;
  endfunction

  function automatic logic signed [SINE_W-1:0] sine_entry(input longint angle);
    longint a;
    longint sum;
    longint term;
    logic   neg;
    a   = angle;
    neg = 1'b0;
    if (a > PI_Q30) begin
      a   = 2 * PI_Q30 - a;
      neg = 1'b1;
    end
    if (a > PI_Q30 / 2) begin
      a = PI_Q30 - a;
    end
    sum  = a;
    term = a;
    term = mul_q30(mul_q30(term, a), a) / 6;
    sum  = sum - term;
    term = mul_q30(mul_q30(term, a), a) / 20;
    sum  = sum + term;
    term = mul_q30(mul_q30(term, a), a) / 42;
    sum  = sum - term;
    term = mul_q30(mul_q30(term, a), a) / 72;
    sum  = sum + term;
    term = mul_q30(mul_q30(term, a), a) / 110;
    sum  = sum - term;
    term = mul_q30(mul_q30(term, a), a) / 156;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    sum = (sum * 32767 + ONE_Q30 / 2) >>> 30;
    if (neg) begin
      sum = -sum;
    end
    sine_entry = SINE_W'(sum);
  endfunction

endpackage

/* rtl/mfd_ram.sv */
// Generic simple dual-port RAM: one write port, two registered read ports.
module mfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/mfd_sine_rom.sv */
// Q1.15 sine lookup ROM with registered read.
module mfd_sine_rom
  import mfd_pkg::*;
#(
  parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [$clog2(SINE_TABLE_SIZE)-1:0] addr_i,
  output logic signed [SINE_W-1:0]           data_o
);

  logic signed [SINE_W-1:0] rom [SINE_TABLE_SIZE];
  logic signed [SINE_W-1:0] data_q;

  for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_rom
    localparam longint Angle = (2 * PI_Q30 * longint'(k)) / SINE_TABLE_SIZE;
    assign rom[k] = sine_entry(Angle);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

/* rtl/mfd_ctrl.sv */
// Sequencing state machine and output handshake for the modulated fractional delay unit.
module mfd_ctrl
  import mfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  mfd_sts_t  sts_i,
  output mfd_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TOT,
    ST_RD,
    ST_MAC,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul  = (state_q == ST_MUL);
    cmd_o.tot  = (state_q == ST_TOT);
    cmd_o.rd   = (state_q == ST_RD);
    cmd_o.mac  = (state_q == ST_MAC);
    cmd_o.fin  = (state_q == ST_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= sts_i.bypass ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_TOT;
        ST_TOT: state_q <= ST_RD;
        ST_RD:  state_q <= ST_MAC;
        ST_MAC: state_q <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/mfd_datapath.sv */
// LFO, delay saturation, tap addressing, interpolation and per-channel state.
module mfd_datapath
  import mfd_pkg::*;
#(
  parameter int BUFFER_DEPTH    = BUFFER_DEPTH_DEF,
  parameter int CHANNELS        = CHANNELS_DEF,
  parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mfd_cmd_t                   cmd_i,
  output mfd_sts_t                   sts_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       channel_id_i,
  input  logic [DELAY_W-1:0]         delay_q8_i,
  input  logic [DEPTH_W-1:0]         depth_q8_i,
  input  logic [PHASE_W-1:0]         phase_step_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  localparam int PTR_W  = $clog2(BUFFER_DEPTH);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SIN_AW = $clog2(SINE_TABLE_SIZE);
  localparam int AW     = CH_W + PTR_W;
  localparam int TOT_W  = (PTR_W + FRAC_W + 2 > 25) ? PTR_W + FRAC_W + 2 : 25;
  localparam int PROD_W = DEPTH_W + SINE_W + 1;
  localparam int LFO_W  = PROD_W - 15;
  localparam int MAC_W  = SAMPLE_W + 10;
  localparam int ACC_W  = MAC_W + 1;
  localparam logic signed [TOT_W-1:0] MaxQ = TOT_W'((BUFFER_DEPTH - 2) * 256);
  localparam logic [PTR_W:0]          DepthX = (PTR_W + 1)'(BUFFER_DEPTH);

  logic [PTR_W-1:0]          wp_q    [CHANNELS];
  logic                      wrap_q  [CHANNELS];
  logic [PHASE_W-1:0]        phase_q [CHANNELS];

  logic signed [SAMPLE_W-1:0] x_q;
  logic [CH_W-1:0]            ch_q;
  logic                       byp_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [PTR_W-1:0]           d1_q;
  logic [FRAC_W-1:0]          f_q;
  logic                       v1_q;
  logic                       v2_q;
  logic signed [MAC_W-1:0]    p1_q;
  logic signed [MAC_W-1:0]    p2_q;
  logic signed [SAMPLE_W-1:0] sample_out_q;

  logic [CH_W-1:0]            ch_in;
  logic signed [SINE_W-1:0]   rom_data;
  logic signed [LFO_W-1:0]    lfo;
  logic signed [TOT_W-1:0]    tot_sum;
  logic signed [TOT_W-1:0]    tot_sat;
  logic [PTR_W-1:0]           wp_cur;
  logic [PTR_W:0]             diff1;
  logic [PTR_W:0]             diff2;
  logic [PTR_W-1:0]           idx1;
  logic [PTR_W-1:0]           idx2;
  logic [SAMPLE_W-1:0]        rd1;
  logic [SAMPLE_W-1:0]        rd2;
  logic signed [SAMPLE_W-1:0] t1;
  logic signed [SAMPLE_W-1:0] t2;
  logic [FRAC_W:0]            w1;
  logic signed [ACC_W-1:0]    acc;

  assign ch_in = CH_W'(channel_id_i);
  assign sts_o.bypass = (delay_q8_i[DELAY_W-1:FRAC_W] == '0) ||
                        (32'(channel_id_i) >= 32'(CHANNELS));

  mfd_sine_rom #(
    .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (cmd_i.load),
    .addr_i (phase_q[ch_in][PHASE_W-1 -: SIN_AW]),
    .data_o (rom_data)
  );

  assign lfo     = LFO_W'(prod_q >>> 15);
  assign tot_sum = TOT_W'($signed({1'b0, delay_q8_i})) + TOT_W'(lfo);

  always_comb begin
    if (tot_sum < 0) begin
      tot_sat = '0;
    end else if (tot_sum > MaxQ) begin
      tot_sat = MaxQ;
    end else begin
      tot_sat = tot_sum;
    end
  end

  assign wp_cur = wp_q[ch_q];
  assign diff1  = {1'b0, wp_cur} - {1'b0, d1_q};
  assign diff2  = diff1 - (PTR_W + 1)'(1);
  assign idx1   = diff1[PTR_W] ? PTR_W'(diff1 + DepthX) : diff1[PTR_W-1:0];
  assign idx2   = diff2[PTR_W] ? PTR_W'(diff2 + DepthX) : diff2[PTR_W-1:0];

  mfd_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(1 << AW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (cmd_i.fin && !byp_q),
    .waddr_i   ({ch_q, wp_cur}),
    .wdata_i   (x_q),
    .re_i      (cmd_i.rd),
    .raddr_a_i ({ch_q, idx1}),
    .raddr_b_i ({ch_q, idx2}),
    .rdata_a_o (rd1),
    .rdata_b_o (rd2)
  );

  assign t1  = v1_q ? $signed(rd1) : '0;
  assign t2  = v2_q ? $signed(rd2) : '0;
  assign w1  = (FRAC_W + 1)'(256) - {1'b0, f_q};
  assign acc = ACC_W'(p1_q) + ACC_W'(p2_q) + ACC_W'(128);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= sample_in_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'($signed({1'b0, depth_q8_i})) * PROD_W'(rom_data);
    end
    if (cmd_i.tot) begin
      d1_q <= tot_sat[PTR_W+FRAC_W-1:FRAC_W];
      f_q  <= tot_sat[FRAC_W-1:0];
    end
    if (cmd_i.rd) begin
      v1_q <= wrap_q[ch_q] || (idx1 < wp_cur);
      v2_q <= wrap_q[ch_q] || (idx2 < wp_cur);
    end
    if (cmd_i.mac) begin
      p1_q <= MAC_W'(t1) * MAC_W'($signed({1'b0, w1}));
      p2_q <= MAC_W'(t2) * MAC_W'($signed({1'b0, f_q}));
    end
    if (cmd_i.fin) begin
      sample_out_q <= byp_q ? x_q : acc[SAMPLE_W+FRAC_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q  <= '0;
      byp_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wp_q[c]    <= '0;
        wrap_q[c]  <= 1'b0;
        phase_q[c] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        ch_q  <= ch_in;
        byp_q <= sts_o.bypass;
      end
      if (cmd_i.fin && !byp_q) begin
        phase_q[ch_q] <= phase_q[ch_q] + phase_step_i;
        if (wp_cur == PTR_W'(BUFFER_DEPTH - 1)) begin
          wp_q[ch_q]   <= '0;
          wrap_q[ch_q] <= 1'b1;
        end else begin
          wp_q[ch_q] <= wp_cur + PTR_W'(1);
        end
      end
    end
  end

  assign sample_out_o = sample_out_q;

endmodule

/* rtl/modulated_fractional_delay_unit.sv */
// Top level: configuration registers, sequencer and datapath of the modulated delay.
// Sequence: an item is taken in ST_IDLE together with the ROM read, then ST_MUL (LFO
// multiply), ST_TOT (saturation), ST_RD (dual tap read), ST_MAC (interpolation products)
// and ST_FIN (write-back) run in turn on one datapath; ST_FIN waits while the output is full,
// and no new item is taken until ST_IDLE is reached again. A bypassed item skips to ST_FIN.
// Reset clears registers, write pointers and LFO phases; unwritten store entries read as
// zero through a per-channel wrap flag, so the block is ready right after reset.
module modulated_fractional_delay_unit
  import mfd_pkg::*;
#(
  parameter int BUFFER_DEPTH    = BUFFER_DEPTH_DEF,
  parameter int CHANNELS        = CHANNELS_DEF,
  parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       channel_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  logic [DELAY_W-1:0]   delay_q8_q;
  logic [DEPTH_W-1:0]   depth_q8_q;
  logic [PHASE_W-1:0]   phase_step_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  mfd_cmd_t             cmd;
  mfd_sts_t             sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q8_q   <= '0;
      depth_q8_q   <= '0;
      phase_step_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DELAY: delay_q8_q   <= pwdata[DELAY_W-1:0];
        REG_DEPTH: depth_q8_q   <= pwdata[DEPTH_W-1:0];
        REG_STEP:  phase_step_q <= pwdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DELAY: prdata = PDATA_W'(delay_q8_q);
      REG_DEPTH: prdata = PDATA_W'(depth_q8_q);
      REG_STEP:  prdata = PDATA_W'(phase_step_q);
      default:   prdata = '0;
    endcase
  end

  mfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mfd_datapath #(
    .BUFFER_DEPTH    (BUFFER_DEPTH),
    .CHANNELS        (CHANNELS),
    .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_in_i  (sample_in_i),
    .channel_id_i (channel_id_i),
    .delay_q8_i   (delay_q8_q),
    .depth_q8_i   (depth_q8_q),
    .phase_step_i (phase_step_q),
    .sample_out_o (sample_out_o)
  );

endmodule

/* bench/testbench.sv */
// Self-checking bench for the LFO-modulated fractional delay unit, with in-bench prediction.
`timescale 1ns / 100ps

module testbench;
  import mfd_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_DEPTH_DEF);
  localparam longint MAX_DELAY_Q8 = longint'(BUFFER_DEPTH_DEF - 2) * 256;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -24'sh800000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic channel_id = 1'b0;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic in_ready;
  logic out_valid;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  logic [DELAY_W-1:0] cfg_delay = '0;
  logic [DEPTH_W-1:0] cfg_depth = '0;
  logic [PHASE_W-1:0] cfg_step = '0;
  logic signed [SAMPLE_W-1:0] line_mem [CHANNELS_DEF][BUFFER_DEPTH_DEF];
  logic [PTR_W-1:0] wr_ptr [CHANNELS_DEF];
  logic [PHASE_W-1:0] lfo_phase [CHANNELS_DEF];
  logic signed [SINE_W-1:0] sine_rom [SINE_TABLE_SIZE_DEF];
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned holdoff_asked = 0;
  int unsigned holdoff_done = 0;
  int unsigned holdoff_left = 0;
  int unsigned quiet_cycles = 0;

  modulated_fractional_delay_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_in_i (sample_in),
    .channel_id_i(channel_id),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .sample_out_o(sample_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [SINE_W-1:0] sine_word(input int k);
    longint ang;
    longint acc;
    longint term;
    logic neg;
    ang = (2 * PI_Q30 * k) / SINE_TABLE_SIZE_DEF;
    neg = (ang > PI_Q30);
    if (neg) begin
      ang = 2 * PI_Q30 - ang;
    end
    if (ang > PI_Q30 / 2) begin
      ang = PI_Q30 - ang;
    end
    acc = ang;
    term = ang;
    for (int n = 1; n <= 6; n++) begin
      term = (term * ang) >>> 30;
      term = (term * ang) >>> 30;
      term = term / ((2 * n) * (2 * n + 1));
      acc = (n % 2 == 1) ? acc - term : acc + term;
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > ONE_Q30) begin
      acc = ONE_Q30;
    end
    acc = (acc * 32767 + ONE_Q30 / 2) >>> 30;
    return SINE_W'(neg ? -acc : acc);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic predict_delay_tap(input logic signed [SAMPLE_W-1:0] x, input logic ch);
    longint lfo;
    longint total;
    longint d1;
    longint frac;
    longint acc;
    logic [PTR_W-1:0] rd1;
    logic [PTR_W-1:0] rd2;
    if (cfg_delay < 256) begin
      expected_samples.push_back(x);
      return;
    end
    lfo = (longint'(cfg_depth) *
           longint'(sine_rom[(64'(lfo_phase[ch]) * SINE_TABLE_SIZE_DEF) >> 32])) >>> 15;
    total = longint'(cfg_delay) + lfo;
    if (total < 0) begin
      total = 0;
    end
    if (total > MAX_DELAY_Q8) begin
      total = MAX_DELAY_Q8;
    end
    d1 = total >>> 8;
    frac = total & 255;
    rd1 = wr_ptr[ch] - PTR_W'(d1);
    rd2 = rd1 - PTR_W'(1);
    acc = longint'(line_mem[ch][rd1]) * (256 - frac) + longint'(line_mem[ch][rd2]) * frac + 128;
    expected_samples.push_back(SAMPLE_W'(acc >>> 8));
    line_mem[ch][wr_ptr[ch]] = x;
    wr_ptr[ch] = wr_ptr[ch] + PTR_W'(1);
    lfo_phase[ch] = lfo_phase[ch] + cfg_step;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic ch);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample_in = x;
    channel_id = ch;
    do @(posedge clk); while (!in_ready);
    predict_delay_tap(x, ch);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] stored;
    case (idx)
      REG_DELAY: stored = PDATA_W'(value[DELAY_W-1:0]);
      REG_DEPTH: stored = PDATA_W'(value[DEPTH_W-1:0]);
      REG_STEP:  stored = value;
      default:   stored = '0;
    endcase
    @(negedge clk);
    in_valid = 1'b0;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PADDR_W'({idx, 2'b00});
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DELAY: cfg_delay = stored[DELAY_W-1:0];
      REG_DEPTH: cfg_depth = stored[DEPTH_W-1:0];
      REG_STEP:  cfg_step = stored;
      default:   ;
    endcase
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      $display("%0t: register %0d read back expected %h got %h", $time, idx, stored, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic test_bypass();
    write_reg(REG_DELAY, 0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample('0, 1'b0);
    send_sample(-24'sd1, 1'b1);
    wait_for_drain();
    write_reg(REG_DELAY, 255);
    send_sample(24'sh123456, 1'b0);
    wait_for_drain();
  endtask

  task automatic test_delay_corners();
    write_reg(REG_DEPTH, 0);
    write_reg(REG_STEP, 32'hC000_0000);
    write_reg(REG_DELAY, 256);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(24'sh55AAAA, 1'b1);
    send_sample(-24'sd1, 1'b0);
    wait_for_drain();
    write_reg(REG_DELAY, 384);
    write_reg(REG_DEPTH, 65535);
    send_sample(24'sh2AAAAA, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(24'sh000100, 1'b1);
    wait_for_drain();
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    write_reg(REG_DELAY, 4194303);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(24'sh7F00FF, 1'b0);
    wait_for_drain();
    write_reg(REG_DEPTH, 0);
    write_reg(REG_DELAY, 32'(MAX_DELAY_Q8));
    send_sample(24'sh400000, 1'b0);
    send_sample(24'sh3FFFFF, 1'b1);
    wait_for_drain();
  endtask

  task automatic test_stall_recovery();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_DELAY, 512);
    write_reg(REG_DEPTH, 256);
    write_reg(REG_STEP, 32'h0100_0000);
    holdoff_asked++;
    repeat (24) send_sample(rand_sample(), 1'($urandom_range(0, 1)));
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned count);
    int unsigned left;
    int unsigned batch;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    left = count;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0: write_reg(REG_DELAY, $urandom_range(0, 255));
        1: write_reg(REG_DELAY, $urandom_range(256, 4194303));
        2: write_reg(REG_DELAY, 4194303);
        default: write_reg(REG_DELAY, $urandom_range(256, 40 * 256));
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(REG_DEPTH, 0);
        1: write_reg(REG_DEPTH, 65535);
        2: write_reg(REG_DEPTH, $urandom_range(0, 65535));
        default: write_reg(REG_DEPTH, $urandom_range(0, 16 * 256));
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(REG_STEP, 0);
        1: write_reg(REG_STEP, 32'hFFFF_FFFF);
        default: write_reg(REG_STEP, $urandom());
      endcase
      batch = $urandom_range(10, 60);
      if (batch > left) begin
        batch = left;
      end
      if ($urandom_range(0, 7) == 0) begin
        holdoff_asked++;
      end
      repeat (batch) send_sample(rand_sample(), 1'($urandom_range(0, 1)));
      left -= batch;
      wait_for_drain();
    end
  endtask

  always @(negedge clk) begin
    if (holdoff_done != holdoff_asked) begin
      holdoff_done = holdoff_asked;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: sample_out expected none got %0d", $time, sample_out);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (sample_out !== want) begin
          $display("%0t: sample_out expected %0d got %0d", $time, want, sample_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      wr_ptr[c] = '0;
      lfo_phase[c] = '0;
      for (int i = 0; i < BUFFER_DEPTH_DEF; i++) begin
        line_mem[c][i] = '0;
      end
    end
    for (int k = 0; k < SINE_TABLE_SIZE_DEF; k++) begin
      sine_rom[k] = sine_word(k);
    end
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_bypass();
    test_delay_corners();
    test_stall_recovery();
    test_random_traffic(30, 84, 310);
    test_random_traffic(84, 30, 310);
    test_random_traffic(0, 0, 310);
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
